[hw/rtl/knsb_pkg.sv]
package knsb_pkg;

    // Buffer depth and derived widths
    localparam int MAX_NEIGHBORS = 16;
    localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W         = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    // Fixed field widths
    localparam int COORD_W    = 16;
    localparam int DIST_W     = 36;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int NC_W       = 5;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int KCMP_W     = (CNT_W > NC_W) ? CNT_W : NC_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CONSIDER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READOUT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Z         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 4'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [CNT_W-1:0]          count_t;

    // One stored entry
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        dist_t  sq_dist;
    } entry_t;

    // One classified item on its way to the back end
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        entry_t            ent;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_rd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STATUS,
        BK_ROT,
        BK_EMIT
    } back_state_t;

endpackage

[hw/rtl/knsb_front.sv]
module knsb_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [knsb_pkg::KIND_W-1:0]      kind,
    input  knsb_pkg::coord_t                 point_x,
    input  knsb_pkg::coord_t                 point_y,
    input  knsb_pkg::coord_t                 point_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [knsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [knsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output knsb_pkg::q_wr_t                  q_wr,
    input  logic                             q_ready,
    output knsb_pkg::count_t                 eff_k
);
    import knsb_pkg::*;

    coord_t            goal_x_reg;
    coord_t            goal_y_reg;
    coord_t            goal_z_reg;
    logic [NC_W-1:0]   nc_reg;
    logic [KCMP_W-1:0] nc_wide;

    logic              adv;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    item_t             s1_item_reg;
    item_t             s2_item_reg;
    item_t             s3_item_reg;
    logic [COORD_W-1:0] s1_mag_reg [3];
    logic [COORD_W-1:0] s1_mag_next [3];
    logic [SQ_W-1:0]    s2_sq_reg [3];
    logic [SQ_W-1:0]    s2_sq_next [3];
    dist_t              s3_dist_next;

    // Absolute difference of two Q8.8 coordinates; always fits 16 bits
    function automatic logic [COORD_W-1:0] abs_diff(input coord_t a, input coord_t b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? COORD_W'((~d) + 1'b1) : d[COORD_W-1:0];
    endfunction

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            goal_z_reg <= '0;
            nc_reg     <= NC_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GOAL_X:         goal_x_reg <= coord_t'(cfg_data[COORD_W-1:0]);
                REG_GOAL_Y:         goal_y_reg <= coord_t'(cfg_data[COORD_W-1:0]);
                REG_GOAL_Z:         goal_z_reg <= coord_t'(cfg_data[COORD_W-1:0]);
                REG_NEIGHBOR_COUNT: nc_reg     <= cfg_data[NC_W-1:0];
                default:            ;
            endcase
        end
    end

    // Effective K: zero counts as one, clipped to the buffer depth
    assign nc_wide = KCMP_W'(nc_reg);

    always_comb
    begin
        if (nc_wide == '0)
            eff_k = CNT_W'(1);
        else if (nc_wide > KCMP_W'(MAX_NEIGHBORS))
            eff_k = CNT_W'(MAX_NEIGHBORS);
        else
            eff_k = CNT_W'(nc_wide);
    end

    // Pipeline moves as a whole when the last stage can drain
    assign adv       = !s3_valid_reg || q_ready;
    assign cmd_stall = !adv;

    always_comb
    begin
        s1_mag_next[0] = abs_diff(point_x, goal_x_reg);
        s1_mag_next[1] = abs_diff(point_y, goal_y_reg);
        s1_mag_next[2] = abs_diff(point_z, goal_z_reg);
        for (int i = 0; i < 3; i++)
            s2_sq_next[i] = s1_mag_reg[i] * s1_mag_reg[i];
        s3_dist_next = DIST_W'(s2_sq_reg[0]) + DIST_W'(s2_sq_reg[1])
                     + DIST_W'(s2_sq_reg[2]);
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= cmd_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payload: differences, squares, sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg.kind        <= kind;
            s1_item_reg.ent.x       <= point_x;
            s1_item_reg.ent.y       <= point_y;
            s1_item_reg.ent.z       <= point_z;
            s1_item_reg.ent.sq_dist <= '0;
            s1_mag_reg              <= s1_mag_next;
            s2_item_reg             <= s1_item_reg;
            s2_sq_reg               <= s2_sq_next;
            s3_item_reg.kind        <= s2_item_reg.kind;
            s3_item_reg.ent.x       <= s2_item_reg.ent.x;
            s3_item_reg.ent.y       <= s2_item_reg.ent.y;
            s3_item_reg.ent.z       <= s2_item_reg.ent.z;
            s3_item_reg.ent.sq_dist <= s3_dist_next;
        end
    end

    assign q_wr.valid = s3_valid_reg;
    assign q_wr.item  = s3_item_reg;

endmodule

[hw/rtl/knsb_queue.sv]
module knsb_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  knsb_pkg::q_wr_t q_wr,
    output logic            q_ready,
    output knsb_pkg::q_rd_t q_rd,
    input  logic            q_pop
);
    import knsb_pkg::*;

    item_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               push;
    logic               pop;

    assign q_ready    = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = q_wr.valid && q_ready;
    assign pop        = q_pop && (cnt_reg != '0);
    assign q_rd.valid = (cnt_reg != '0);
    assign q_rd.item  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= q_wr.item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/knsb_back.sv]
module knsb_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  knsb_pkg::q_rd_t                  q_rd,
    output logic                             q_pop,
    input  knsb_pkg::count_t                 eff_k,
    output logic                             res_valid,
    input  logic                             res_stall,
    output knsb_pkg::coord_t                 entry_x,
    output knsb_pkg::coord_t                 entry_y,
    output knsb_pkg::coord_t                 entry_z,
    output knsb_pkg::dist_t                  distance,
    output logic                             entry_valid,
    output knsb_pkg::count_t                 stored_count,
    output logic                             full_res,
    output logic                             last
);
    import knsb_pkg::*;

    // Cells are right aligned: occupied cells run from MAX-total to MAX-1,
    // nearest at the low end, worst in the top cell except during a readout rotation.
    entry_t      ent_reg  [MAX_NEIGHBORS];
    entry_t      ent_next [MAX_NEIGHBORS];
    logic        vld [MAX_NEIGHBORS];
    logic        le  [MAX_NEIGHBORS];
    logic        gt  [MAX_NEIGHBORS];

    count_t      total_reg;
    count_t      rot_cnt_reg;
    count_t      rot_inc;
    back_state_t state_reg;
    back_state_t state_next;

    entry_t      cand;
    entry_t      top_ent;
    logic        grow_ok;
    logic        repl_ok;
    logic        out_free;
    logic        out_last;

    logic        do_grow;
    logic        do_replace;
    logic        do_clear;
    logic        do_rot;
    logic        start_rd;
    logic        ld_status;
    logic        ld_entry;

    logic        res_valid_reg;
    entry_t      res_ent_reg;
    logic        res_ev_reg;
    count_t      res_cnt_reg;
    logic        res_full_reg;
    logic        res_last_reg;

    assign cand     = q_rd.item.ent;
    assign top_ent  = ent_reg[MAX_NEIGHBORS-1];
    assign grow_ok  = (total_reg < eff_k);
    assign repl_ok  = !grow_ok && (total_reg != '0) && (cand.sq_dist < top_ent.sq_dist);
    assign out_free = !res_valid_reg || !res_stall;
    assign rot_inc  = rot_cnt_reg + 1'b1;
    assign out_last = (rot_cnt_reg == CNT_W'(MAX_NEIGHBORS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_rd.valid)
                begin
                    if (q_rd.item.kind == KIND_READOUT && total_reg != '0)
                        state_next = BK_ROT;
                    else
                        state_next = BK_STATUS;
                end
            end
            BK_STATUS:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            BK_ROT:
            begin
                if (rot_inc > CNT_W'(MAX_NEIGHBORS) - total_reg)
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                    state_next = out_last ? BK_IDLE : BK_ROT;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Controls
    always_comb
    begin
        q_pop      = 1'b0;
        do_grow    = 1'b0;
        do_replace = 1'b0;
        do_clear   = 1'b0;
        do_rot     = 1'b0;
        start_rd   = 1'b0;
        ld_status  = 1'b0;
        ld_entry   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_rd.valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_rd.item.kind)
                        KIND_CONSIDER:
                        begin
                            do_grow    = grow_ok;
                            do_replace = repl_ok;
                        end
                        KIND_READOUT: start_rd = (total_reg != '0);
                        KIND_CLEAR:   do_clear = 1'b1;
                        default:      ;
                    endcase
                end
            end
            BK_STATUS: ld_status = out_free;
            BK_ROT:    do_rot    = 1'b1;
            BK_EMIT:   ld_entry  = out_free;
            default:   ;
        endcase
    end

    // Compare-and-shift cells; the whole row also rotates for readout
    always_comb
    begin
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            vld[i] = (CNT_W'(MAX_NEIGHBORS - i) <= total_reg);
            le[i]  = vld[i] && (ent_reg[i].sq_dist <= cand.sq_dist);
            gt[i]  = vld[i] && (ent_reg[i].sq_dist > cand.sq_dist);
        end
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            ent_next[i] = ent_reg[i];
            if (do_rot)
                ent_next[i] = ent_reg[IDX_W'((i + 1) % MAX_NEIGHBORS)];
            else if (do_grow)
            begin
                // nearer-or-equal entries step down one cell to make room
                if (i != MAX_NEIGHBORS - 1 && le[IDX_W'((i + 1) % MAX_NEIGHBORS)])
                    ent_next[i] = ent_reg[IDX_W'((i + 1) % MAX_NEIGHBORS)];
                else if (le[i] || !vld[i])
                    ent_next[i] = cand;
            end
            else if (do_replace)
            begin
                // farther entries step up one cell, the worst drops out
                if (i != 0 && gt[IDX_W'((i + MAX_NEIGHBORS - 1) % MAX_NEIGHBORS)])
                    ent_next[i] = ent_reg[IDX_W'((i + MAX_NEIGHBORS - 1) % MAX_NEIGHBORS)];
                else if (gt[i])
                    ent_next[i] = cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_NEIGHBORS; i++)
            ent_reg[i] <= ent_next[i];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            total_reg   <= '0;
            rot_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_grow)
                total_reg <= total_reg + 1'b1;
            else if (do_clear)
                total_reg <= '0;
            if (start_rd)
                rot_cnt_reg <= '0;
            else if (do_rot)
                rot_cnt_reg <= rot_inc;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ld_status || ld_entry)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ld_status)
        begin
            res_ent_reg.x       <= '0;
            res_ent_reg.y       <= '0;
            res_ent_reg.z       <= '0;
            res_ent_reg.sq_dist <= (total_reg != '0) ? top_ent.sq_dist : '0;
            res_ev_reg          <= 1'b0;
            res_last_reg        <= 1'b1;
        end
        else if (ld_entry)
        begin
            res_ent_reg      <= top_ent;
            res_ev_reg       <= 1'b1;
            res_last_reg     <= out_last;
        end
        if (ld_status || ld_entry)
        begin
            res_cnt_reg  <= total_reg;
            res_full_reg <= (total_reg >= eff_k);
        end
    end

    assign res_valid    = res_valid_reg;
    assign entry_x      = res_ent_reg.x;
    assign entry_y      = res_ent_reg.y;
    assign entry_z      = res_ent_reg.z;
    assign distance     = res_ent_reg.sq_dist;
    assign entry_valid  = res_ev_reg;
    assign stored_count = res_cnt_reg;
    assign full_res     = res_full_reg;
    assign last         = res_last_reg;

endmodule

[hw/rtl/k_nearest_sorted_buffer.sv]
// k-nearest sorted buffer: keeps up to 16 points nearest to the goal point,
// ordered by exact squared distance (ties after older entries). Every word
// first passes a three-stage distance pipeline (difference, square, sum)
// and a four-word queue, so a word is taken each cycle until the queue
// fills. The back end handles a consider, clear or unused word by comparing
// and shifting all cells in parallel, then posting the status word; for a
// readout of n entries it rotates the whole cell row once round and posts
// each stored entry as it passes the top cell. Considers are therefore
// limited by the back end's update-then-report sequence: it takes no new
// word until the result of the last one is posted.
// Entries need no clearing after reset; the block is ready at once.
// Goal and K registers may be written only while no word is in flight.
module k_nearest_sorted_buffer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [knsb_pkg::KIND_W-1:0]      kind,
    input  knsb_pkg::coord_t                 point_x,
    input  knsb_pkg::coord_t                 point_y,
    input  knsb_pkg::coord_t                 point_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [knsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [knsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             res_valid,
    input  logic                             res_stall,
    output knsb_pkg::coord_t                 entry_x,
    output knsb_pkg::coord_t                 entry_y,
    output knsb_pkg::coord_t                 entry_z,
    output knsb_pkg::dist_t                  distance,
    output logic                             entry_valid,
    output knsb_pkg::count_t                 stored_count,
    output logic                             full_res,
    output logic                             last
);
    import knsb_pkg::*;

    q_wr_t  q_wr;
    q_rd_t  q_rd;
    logic   q_ready;
    logic   q_pop;
    count_t eff_k;

    // Front: configuration and distance pipeline
    knsb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .kind      (kind),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_wr      (q_wr),
        .q_ready   (q_ready),
        .eff_k     (eff_k)
    );

    // Decoupling queue
    knsb_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_ready (q_ready),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    // Back: sorted cells, readout sequencer, result register
    knsb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .q_pop        (q_pop),
        .eff_k        (eff_k),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .entry_z      (entry_z),
        .distance     (distance),
        .entry_valid  (entry_valid),
        .stored_count (stored_count),
        .full_res     (full_res),
        .last         (last)
    );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import knsb_pkg::*;

    // Codes the package does not name
    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 4'd12;
    localparam logic [CFG_IDX_W-1:0] GOAL_REGS [3] = '{REG_GOAL_X, REG_GOAL_Y, REG_GOAL_Z};

    localparam coord_t C_MAX    = 16'h7FFF;
    localparam coord_t C_MIN    = 16'h8000;
    localparam dist_t  FAR_DIST = 36'd12884508675;   // 3 * 65535^2

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int SETTLE_CYCLES   = 60;
    localparam int MAX_PRINTS      = 50;

    // One result word as seen on the output port
    typedef struct packed {
        coord_t ex;
        coord_t ey;
        coord_t ez;
        dist_t  sq_dist;
        logic   ev;
        count_t cnt;
        logic   full;
        logic   last;
    } res_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_op_t;
    typedef enum {PT_NEAR, PT_RANDOM, PT_GOAL, PT_REPEAT, PT_EXTREME} pt_mode_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // Directed stimulus row: an item or a register write
    typedef struct {
        row_op_t                op;
        logic [KIND_W-1:0]      kind;
        coord_t                 x;
        coord_t                 y;
        coord_t                 z;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     typed;
        res_t                   want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    cmd_valid   = 1'b0;
    logic                    cmd_stall;
    logic [KIND_W-1:0]       kind        = '0;
    coord_t                  point_x     = '0;
    coord_t                  point_y     = '0;
    coord_t                  point_z     = '0;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;
    logic                    res_valid;
    logic                    res_stall   = 1'b0;
    coord_t                  entry_x;
    coord_t                  entry_y;
    coord_t                  entry_z;
    dist_t                   distance;
    logic                    entry_valid;
    count_t                  stored_count;
    logic                    full_res;
    logic                    last;

    k_nearest_sorted_buffer u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .kind         (kind),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .entry_z      (entry_z),
        .distance     (distance),
        .entry_valid  (entry_valid),
        .stored_count (stored_count),
        .full_res     (full_res),
        .last         (last)
    );

    // Buffer model state and its copy of the registers
    coord_t      goal_x_m = '0;
    coord_t      goal_y_m = '0;
    coord_t      goal_z_m = '0;
    logic [4:0]  k_reg    = 5'd1;
    coord_t      kept_x    [MAX_NEIGHBORS];
    coord_t      kept_y    [MAX_NEIGHBORS];
    coord_t      kept_z    [MAX_NEIGHBORS];
    dist_t       kept_dist [MAX_NEIGHBORS];
    int          kept_total = 0;

    res_t        expected_words [$];
    stim_row_t   dir_tab [$];

    int          errors        = 0;
    int          words_checked = 0;
    int          kind_seen [4] = '{0, 0, 0, 0};
    int          k_writes      = 0;
    int          burst_left    = 0;
    bit          no_gaps       = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("timeout: %0d result words still outstanding", expected_words.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Append to the list of awaited result words
    function automatic void expect_word(res_t w);
        expected_words = {expected_words, w};
    endfunction

    // Append a row to the directed table
    function automatic void add_row(stim_row_t r);
        dir_tab = {dir_tab, r};
    endfunction

    // Clamp K into 1..MAX_NEIGHBORS
    function automatic int active_k();
        int k;
        k = k_reg;
        if (k == 0)
            k = 1;
        if (k > MAX_NEIGHBORS)
            k = MAX_NEIGHBORS;
        return k;
    endfunction

    // Exact squared distance to the goal
    function automatic dist_t sq_distance(coord_t x, coord_t y, coord_t z);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(x) - longint'(goal_x_m);
        dy = longint'(y) - longint'(goal_y_m);
        dz = longint'(z) - longint'(goal_z_m);
        return dist_t'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Insert into the first n entries; equal distances stay ahead
    function automatic void place_sorted(int n, coord_t x, coord_t y, coord_t z, dist_t d);
        int pos;
        pos = 0;
        while (pos < n && kept_dist[pos] <= d)
            pos++;
        for (int i = n; i > pos; i--)
        begin
            kept_x[i]    = kept_x[i-1];
            kept_y[i]    = kept_y[i-1];
            kept_z[i]    = kept_z[i-1];
            kept_dist[i] = kept_dist[i-1];
        end
        kept_x[pos]    = x;
        kept_y[pos]    = y;
        kept_z[pos]    = z;
        kept_dist[pos] = d;
    endfunction

    // Status word, or one stored entry on readout
    function automatic res_t buffer_word(int idx, bit with_entry, bit is_last);
        res_t w;
        w = '0;
        if (with_entry)
        begin
            w.ex      = kept_x[idx];
            w.ey      = kept_y[idx];
            w.ez      = kept_z[idx];
            w.sq_dist = kept_dist[idx];
        end
        else if (kept_total > 0)
            w.sq_dist = kept_dist[kept_total-1];
        w.ev   = with_entry;
        w.cnt  = count_t'(kept_total);
        w.full = (kept_total >= active_k());
        w.last = is_last;
        return w;
    endfunction

    // Apply one accepted word; queue its results when post is set
    function automatic void buffer_model_step(logic [KIND_W-1:0] k, coord_t x, coord_t y,
                                              coord_t z, bit post);
        dist_t d;
        if (k == KIND_CONSIDER)
        begin
            d = sq_distance(x, y, z);
            if (kept_total < active_k())
            begin
                place_sorted(kept_total, x, y, z, d);
                kept_total++;
            end
            else if (kept_total > 0 && d < kept_dist[kept_total-1])
                place_sorted(kept_total - 1, x, y, z, d);
        end
        else if (k == KIND_CLEAR)
            kept_total = 0;

        if (!post)
            return;
        if (k == KIND_READOUT && kept_total > 0)
        begin
            for (int i = 0; i < kept_total; i++)
                expect_word(buffer_word(i, 1'b1, i == kept_total - 1));
        end
        else
            expect_word(buffer_word(0, 1'b0, 1'b1));
    endfunction

    function automatic res_t status_word(dist_t d, count_t c, logic f);
        res_t w;
        w         = '0;
        w.sq_dist = d;
        w.cnt     = c;
        w.full    = f;
        w.last    = 1'b1;
        return w;
    endfunction

    function automatic stim_row_t item_row(logic [KIND_W-1:0] k, coord_t x, coord_t y,
                                           coord_t z, bit typed = 1'b0, res_t want = '0);
        stim_row_t r;
        r.op    = ROW_ITEM;
        r.kind  = k;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.idx   = '0;
        r.data  = '0;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r       = item_row(KIND_CONSIDER, '0, '0, '0);
        r.op    = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    function automatic coord_t pick_coord(coord_t g, pt_mode_t m);
        case (m)
            PT_NEAR:    return coord_t'(int'(g) + int'($urandom_range(0, 512)) - 256);
            PT_GOAL:    return g;
            PT_EXTREME: return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default:    return coord_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Present one word and hold it until taken
    task automatic send_word(input logic [KIND_W-1:0] k, input coord_t x, input coord_t y,
                             input coord_t z, input bit typed = 1'b0, input res_t want = '0);
        cmd_valid <= 1'b1;
        cfg_valid <= 1'b0;
        kind      <= k;
        point_x   <= x;
        point_y   <= y;
        point_z   <= z;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        buffer_model_step(k, x, y, z, !typed);
        if (typed)
            expect_word(want);
        kind_seen[k]++;
    endtask

    // Sender bursts with random gaps between them
    task automatic sender_pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every expected word has come back
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // One register write, then a pause with the write channel idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GOAL_X:         goal_x_m = coord_t'(data);
            REG_GOAL_Y:         goal_y_m = coord_t'(data);
            REG_GOAL_Z:         goal_z_m = coord_t'(data);
            REG_NEIGHBOR_COUNT:
            begin
                k_reg = data[4:0];
                k_writes++;
            end
            default:            ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver stall pattern, switching mode when its random hold count runs out
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          cyc        = 0;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:  res_stall <= 1'b0;
            STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 6);
            default:     res_stall <= ((cyc % 5) < 2);
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin : res_check
        res_t got;
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            got.ex      = entry_x;
            got.ey      = entry_y;
            got.ez      = entry_z;
            got.sq_dist = distance;
            got.ev      = entry_valid;
            got.cnt     = stored_count;
            got.full    = full_res;
            got.last    = last;
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, distance", got.sq_dist, 0);
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (got.ex !== want.ex)     report_mismatch("entry_x", got.ex, want.ex);
                if (got.ey !== want.ey)     report_mismatch("entry_y", got.ey, want.ey);
                if (got.ez !== want.ez)     report_mismatch("entry_z", got.ez, want.ez);
                if (got.sq_dist !== want.sq_dist)
                    report_mismatch("distance", got.sq_dist, want.sq_dist);
                if (got.ev !== want.ev)     report_mismatch("entry_valid", got.ev, want.ev);
                if (got.cnt !== want.cnt)   report_mismatch("stored_count", got.cnt, want.cnt);
                if (got.full !== want.full) report_mismatch("full_res", got.full, want.full);
                if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    // Stimulus
    initial
    begin : stim
        int                     r;
        int                     kval;
        logic [KIND_W-1:0]      k;
        logic [CFG_DATA_W-1:0]  gd;
        pt_mode_t               pm;
        coord_t                 px;
        coord_t                 py;
        coord_t                 pz;

        px = '0;
        py = '0;
        pz = '0;

        // Reset settings: goal at origin, K of one
        add_row(item_row(KIND_READOUT, 0, 0, 0, 1'b1, status_word(0, 0, 1'b0)));
        add_row(item_row(KIND_CONSIDER, 0, 0, 0, 1'b1, status_word(0, 1, 1'b1)));
        // full and not strictly nearer: ignored
        add_row(item_row(KIND_CONSIDER, C_MIN, C_MIN, C_MIN, 1'b1,
                         status_word(0, 1, 1'b1)));
        add_row(item_row(KIND_UNUSED, C_MAX, C_MAX, C_MAX, 1'b1,
                         status_word(0, 1, 1'b1)));
        add_row(item_row(KIND_READOUT, 0, 0, 0, 1'b1,
                         res_t'{16'sd0, 16'sd0, 16'sd0, 36'd0, 1'b1, 5'd1,
                                1'b1, 1'b1}));
        add_row(item_row(KIND_CLEAR, 0, 0, 0, 1'b1, status_word(0, 0, 1'b0)));

        // Goal at a corner, largest K, plus a write to an unused index
        add_row(cfg_row(REG_GOAL_X, 16'h7FFF));
        add_row(cfg_row(REG_GOAL_Y, 16'h8000));
        add_row(cfg_row(REG_GOAL_Z, 16'h7FFF));
        add_row(cfg_row(REG_NEIGHBOR_COUNT, 16'd16));
        add_row(cfg_row(REG_UNUSED, 16'hFFFF));
        add_row(item_row(KIND_CONSIDER, C_MIN, C_MAX, C_MIN, 1'b1,
                         status_word(FAR_DIST, 1, 1'b0)));
        add_row(item_row(KIND_CONSIDER, C_MAX, C_MIN, C_MAX, 1'b1,
                         status_word(FAR_DIST, 2, 1'b0)));
        // ties at both ends of the range
        add_row(item_row(KIND_CONSIDER, C_MAX, C_MIN, C_MAX));
        add_row(item_row(KIND_CONSIDER, C_MIN, C_MAX, C_MIN));
        add_row(item_row(KIND_CONSIDER, 0, 0, 0));
        add_row(item_row(KIND_CONSIDER, 16'h0100, 16'hFF00, 16'h7F00));
        add_row(item_row(KIND_CONSIDER, 16'h5555, 16'hAAAA, 16'h5555));
        add_row(item_row(KIND_READOUT, 0, 0, 0));

        // K lowered below the count: entries kept, worst one replaced
        add_row(cfg_row(REG_NEIGHBOR_COUNT, 16'd2));
        add_row(item_row(KIND_CONSIDER, C_MIN, C_MAX, C_MIN));
        add_row(item_row(KIND_CONSIDER, 16'h7FFE, C_MIN, C_MAX));
        add_row(item_row(KIND_READOUT, 0, 0, 0));

        // K of zero acts as one
        add_row(cfg_row(REG_NEIGHBOR_COUNT, 16'h0000));
        add_row(item_row(KIND_CLEAR, 0, 0, 0));
        add_row(item_row(KIND_CONSIDER, 1, 2, 3));
        add_row(item_row(KIND_CONSIDER, C_MAX, C_MIN, C_MAX));
        add_row(item_row(KIND_READOUT, 0, 0, 0));

        // K above the depth clamps to the depth
        add_row(cfg_row(REG_NEIGHBOR_COUNT, 16'hFFFF));
        add_row(item_row(KIND_CONSIDER, 16'h7FF0, 16'h8010, 16'h7FF0));
        add_row(item_row(KIND_CONSIDER, -1, -1, -1));
        add_row(item_row(KIND_READOUT, 0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == ROW_CFG)
            begin
                wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
            begin
                sender_pace();
                send_word(dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                          dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // Random phases, each with its own goal and K; buffer not cleared between them
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            for (int a = 0; a < 3; a++)
            begin
                gd = (p == 1) ? 16'h8000 : (p == 3) ? 16'h7FFF : 16'($urandom_range(0, 65535));
                write_reg(GOAL_REGS[a], gd);
            end
            case (p)
                0:       kval = 16;
                1:       kval = 1;
                2:       kval = 0;
                3:       kval = 31;
                4:       kval = 2;
                default: kval = $urandom_range(0, 31);
            endcase
            write_reg(REG_NEIGHBOR_COUNT, {11'($urandom_range(0, 2047)), 5'(kval)});
            no_gaps = (p % 3 == 2);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                    k = KIND_CONSIDER;
                else if (r < 90)
                    k = KIND_READOUT;
                else if (r < 96)
                    k = KIND_CLEAR;
                else
                    k = KIND_UNUSED;
                r = $urandom_range(0, 9);
                pm = (r < 4) ? PT_NEAR : (r == 6) ? PT_GOAL : (r == 7) ? PT_REPEAT :
                     (r == 8) ? PT_EXTREME : PT_RANDOM;
                // a repeat keeps the previous point, giving exact ties
                if (pm != PT_REPEAT)
                begin
                    px = pick_coord(goal_x_m, pm);
                    py = pick_coord(goal_y_m, pm);
                    pz = pick_coord(goal_z_m, pm);
                end
                sender_pace();
                send_word(k, px, py, pz);
            end
        end

        // Drain, then give the block time to show any stray words
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("words never delivered", expected_words.size(), 0);

        $display("covered %0d considers, %0d readouts, %0d clears, %0d unused-kind words",
                 kind_seen[KIND_CONSIDER], kind_seen[KIND_READOUT], kind_seen[KIND_CLEAR],
                 kind_seen[KIND_UNUSED]);
        $display("%0d result words checked across %0d K settings, %0d mismatches",
                 words_checked, k_writes, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
